FILE: rtl/core/ptre_pkg.sv
// package for the pixel triple rle text encoder
// holds widths, text codes and the result list type shared by all core files
`timescale 1ns / 1ps

package ptre_pkg;

  // field and state widths
  localparam int BYTE_W  = 8;
  localparam int PIX_W   = 3 * BYTE_W;
  localparam int CHAR_W  = 7;
  localparam int RUN_W   = 5;
  localparam int CNT_W   = 10;

  // results caused by one pixel, and the index width that covers them
  localparam int MAX_RES = 6;
  localparam int IDX_W   = $clog2(MAX_RES + 1);

  // default depth of the list queue between front and back
  localparam int Q_DEPTH_DEF = 2;

  // register reset
  localparam logic [CNT_W-1:0] LIMIT_RESET = 10'd190;

  // text codes
  localparam logic [CHAR_W-1:0] RUN_BASE    = 7'd98;
  localparam logic [RUN_W-1:0]  RUN_CLOSE   = 5'd26;
  localparam logic [CHAR_W-1:0] WHITE_CODE  = 7'd33;
  localparam logic [CHAR_W-1:0] BLACK_CODE  = 7'd127;
  localparam logic [CHAR_W-1:0] CHAR_OFFSET = 7'd35;
  localparam logic [CHAR_W-1:0] ESC_FROM    = 7'd92;
  localparam logic [CHAR_W-1:0] ESC_TO      = 7'd125;
  localparam logic [CHAR_W-1:0] BREAK_CODE  = 7'd0;

  // pixel values with a code of their own
  localparam logic [PIX_W-1:0] WHITE_PIX = 24'hFFFFFF;
  localparam logic [PIX_W-1:0] BLACK_PIX = 24'h000000;

  // ordered list of results for one pixel
  typedef struct packed {
    logic [IDX_W-1:0]                cnt;
    logic [MAX_RES-1:0]              brk;
    logic [MAX_RES-1:0][CHAR_W-1:0]  chars;
  } res_list_t;

endpackage

FILE: rtl/core/ptre_if.sv
// valid/ready channel interfaces for pixel requests and text results
// depends on ptre_pkg for field widths
`timescale 1ns / 1ps

interface ptre_pix_if;
  import ptre_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] first_byte;
  logic [BYTE_W-1:0] second_byte;
  logic [BYTE_W-1:0] third_byte;
  logic              last_pixel;

  modport source (
    output valid, first_byte, second_byte, third_byte, last_pixel,
    input  ready
  );
  modport sink (
    input  valid, first_byte, second_byte, third_byte, last_pixel,
    output ready
  );
endinterface

interface ptre_res_if;
  import ptre_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] out_char;
  logic              is_break;
  logic              last_of_item;

  modport source (
    output valid, out_char, is_break, last_of_item,
    input  ready
  );
  modport sink (
    input  valid, out_char, is_break, last_of_item,
    output ready
  );
endinterface

FILE: rtl/core/ptre_front.sv
// front end: accepts pixels, tracks run and segment state, builds result lists
// depends on ptre_pkg and ptre_pix_if
`timescale 1ns / 1ps

module ptre_front (
  input  logic                    clk,
  input  logic                    rst_n,
  ptre_pix_if.sink                in_pix,
  input  logic                    cfg_we,
  input  logic [ptre_pkg::CNT_W-1:0] cfg_wdata,
  input  logic                    q_full,
  output logic                    push,
  output ptre_pkg::res_list_t     push_list
);
  import ptre_pkg::*;

  // offset a 6-bit field into printable range, escaping the backslash code
  function automatic logic [CHAR_W-1:0] text_code(input logic [5:0] v);
    logic [CHAR_W-1:0] c;
    c = {1'b0, v} + CHAR_OFFSET;
    return (c == ESC_FROM) ? ESC_TO : c;
  endfunction

  logic [CNT_W-1:0] limit_r;
  logic [PIX_W-1:0] prev_r, prev_nxt;
  logic [RUN_W-1:0] run_r, run_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  logic [PIX_W-1:0] pix;
  logic [CNT_W:0]   cnt_w;
  logic [IDX_W-1:0] n;
  logic [5:0]       top;
  res_list_t        lst;
  logic             accept;

  assign in_pix.ready = !q_full;
  assign accept       = in_pix.valid && in_pix.ready;
  assign pix          = {in_pix.first_byte, in_pix.second_byte, in_pix.third_byte};
  assign top          = {in_pix.third_byte[7:6], in_pix.second_byte[7:6],
                         in_pix.first_byte[7:6]};

  // classify the pixel and append its results in order
  always_comb begin
    run_nxt  = run_r;
    cnt_w    = {1'b0, count_r};
    prev_nxt = prev_r;
    lst      = '0;
    n        = '0;

    if (pix == prev_r) begin
      if (run_nxt == '0) begin
        run_nxt = RUN_W'(1);
        cnt_w   = cnt_w + (CNT_W+1)'(1);
      end else begin
        run_nxt = run_nxt + RUN_W'(1);
        // full run closes at once
        if (run_nxt >= RUN_CLOSE) begin
          lst.chars[n] = RUN_BASE + CHAR_W'(run_nxt);
          n            = n + IDX_W'(1);
          run_nxt      = '0;
        end
      end
    end else begin
      // new pixel ends any pending run
      if (run_nxt != '0) begin
        lst.chars[n] = RUN_BASE + CHAR_W'(run_nxt);
        n            = n + IDX_W'(1);
        run_nxt      = '0;
      end
      prev_nxt = pix;
      if (pix == WHITE_PIX) begin
        lst.chars[n] = WHITE_CODE;
        n            = n + IDX_W'(1);
        cnt_w        = cnt_w + (CNT_W+1)'(1);
      end else if (pix == BLACK_PIX) begin
        lst.chars[n] = BLACK_CODE;
        n            = n + IDX_W'(1);
        cnt_w        = cnt_w + (CNT_W+1)'(1);
      end else begin
        lst.chars[n] = text_code(in_pix.first_byte[5:0]);
        n            = n + IDX_W'(1);
        lst.chars[n] = text_code(in_pix.second_byte[5:0]);
        n            = n + IDX_W'(1);
        lst.chars[n] = text_code(in_pix.third_byte[5:0]);
        n            = n + IDX_W'(1);
        lst.chars[n] = text_code(top);
        n            = n + IDX_W'(1);
        cnt_w        = cnt_w + (CNT_W+1)'(4);
      end
    end

    // segment break, preceded by any pending run
    if (cnt_w > {1'b0, limit_r}) begin
      if (run_nxt != '0) begin
        lst.chars[n] = RUN_BASE + CHAR_W'(run_nxt);
        n            = n + IDX_W'(1);
        run_nxt      = '0;
      end
      lst.chars[n] = BREAK_CODE;
      lst.brk[n]   = 1'b1;
      n            = n + IDX_W'(1);
      cnt_w        = '0;
    end
    count_nxt = cnt_w[CNT_W-1:0];

    // end of image flushes the run
    if (in_pix.last_pixel && (run_nxt != '0)) begin
      lst.chars[n] = RUN_BASE + CHAR_W'(run_nxt);
      n            = n + IDX_W'(1);
      run_nxt      = '0;
    end

    lst.cnt = n;
  end

  assign push      = accept && (n != '0);
  assign push_list = lst;

  // encoder state and limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
      prev_r  <= '0;
      run_r   <= '0;
      count_r <= '0;
    end else begin
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
      if (accept) begin
        prev_r  <= prev_nxt;
        run_r   <= run_nxt;
        count_r <= count_nxt;
      end
    end
  end

endmodule

FILE: rtl/core/ptre_queue.sv
// small queue of result lists between front end and back end
// depends on ptre_pkg for the list type
`timescale 1ns / 1ps

module ptre_queue #(
  parameter int DEPTH = ptre_pkg::Q_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  ptre_pkg::res_list_t push_data,
  output logic                full,
  input  logic                pop,
  output logic                valid,
  output ptre_pkg::res_list_t pop_data
);
  import ptre_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int OCC_W = $clog2(DEPTH + 1);

  res_list_t              mem_r [DEPTH];
  logic [PTR_W-1:0]       wr_ptr_r, rd_ptr_r;
  logic [OCC_W-1:0]       occ_r;

  assign full     = (occ_r == OCC_W'(DEPTH));
  assign valid    = (occ_r != '0);
  assign pop_data = mem_r[rd_ptr_r];

  // pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      occ_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        occ_r <= occ_r + OCC_W'(1);
      end else if (pop && !push) begin
        occ_r <= occ_r - OCC_W'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: rtl/core/ptre_back.sv
// back end: walks each result list and sends one text code per cycle while out_res is ready
// depends on ptre_pkg and ptre_res_if
`timescale 1ns / 1ps

module ptre_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  ptre_pkg::res_list_t q_data,
  output logic                q_pop,
  ptre_res_if.source          out_res
);
  import ptre_pkg::*;

  res_list_t         cur_r;
  logic [IDX_W-1:0]  idx_r;
  logic              busy_r;
  logic              ov_r;
  logic [CHAR_W-1:0] och_r;
  logic              obrk_r;
  logic              olast_r;
  logic              ld;
  logic              cur_end;
  logic              head_end;

  // output slot is free or being emptied
  assign ld       = !ov_r || out_res.ready;
  assign q_pop    = ld && !busy_r && q_valid;
  assign cur_end  = (idx_r == cur_r.cnt - IDX_W'(1));
  assign head_end = (q_data.cnt == IDX_W'(1));

  assign out_res.valid        = ov_r;
  assign out_res.out_char     = och_r;
  assign out_res.is_break     = obrk_r;
  assign out_res.last_of_item = olast_r;

  // sequencing control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r   <= 1'b0;
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else if (ld) begin
      if (busy_r) begin
        ov_r   <= 1'b1;
        busy_r <= !cur_end;
        idx_r  <= idx_r + IDX_W'(1);
      end else if (q_valid) begin
        ov_r   <= 1'b1;
        busy_r <= !head_end;
        idx_r  <= IDX_W'(1);
      end else begin
        ov_r   <= 1'b0;
      end
    end
  end

  // output payload and current list
  always_ff @(posedge clk) begin
    if (ld) begin
      if (busy_r) begin
        och_r   <= cur_r.chars[idx_r];
        obrk_r  <= cur_r.brk[idx_r];
        olast_r <= cur_end;
      end else if (q_valid) begin
        cur_r   <= q_data;
        och_r   <= q_data.chars[0];
        obrk_r  <= q_data.brk[0];
        olast_r <= head_end;
      end
    end
  end

endmodule

FILE: rtl/core/pixel_triple_rle_text_encoder.sv
// pixel triple rle text encoder: one pixel request in, zero to six text codes out
// path: the first code of a pixel passes the queue storage, then the back end output register
// throughput: one code per cycle at the output register while out_res is ready; a literal
//   pixel gives four codes, a white, black or run code one, an item that only extends a run none
// reset: state, run and count cleared, previous pixel zero, limit 190, queue empty
`timescale 1ns / 1ps

module pixel_triple_rle_text_encoder #(
  parameter int Q_DEPTH = ptre_pkg::Q_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  ptre_pix_if.sink                   in_pix,
  ptre_res_if.source                 out_res,
  input  logic                       cfg_we,
  input  logic [ptre_pkg::CNT_W-1:0] cfg_wdata
);
  import ptre_pkg::*;

  logic      q_push;
  logic      q_full;
  logic      q_valid;
  logic      q_pop;
  res_list_t push_list;
  res_list_t head_list;

  // classify and build result lists
  ptre_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_pix    (in_pix),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_full    (q_full),
    .push      (q_push),
    .push_list (push_list)
  );

  // decoupling queue
  ptre_queue #(
    .DEPTH (Q_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_list),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_data  (head_list)
  );

  // serialize to the result channel
  ptre_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_data  (head_list),
    .q_pop   (q_pop),
    .out_res (out_res)
  );

  // no list is written into a full queue
  assert property (@(posedge clk) disable iff (!rst_n) q_push |-> !q_full)
    else $error("push into full queue");

  // the back end only pops a list that is present
  assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_valid)
    else $error("pop from empty queue");

  // a queued list holds between one and six results
  assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (push_list.cnt != '0) && (push_list.cnt <= IDX_W'(MAX_RES)))
    else $error("result list length out of range");

endmodule
